### hdl/ps2mt_pkg.sv
package ps2mt_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned CFG_W           = 13;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned COORD_BITS_DEF  = 12;
  localparam int unsigned CURSOR_RST      = 100;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

  // Header byte bit positions
  localparam int unsigned SYNC_BIT   = 3;
  localparam int unsigned BTN_LEFT   = 0;
  localparam int unsigned BTN_RIGHT  = 1;
  localparam int unsigned BTN_MIDDLE = 2;

endpackage

### hdl/ps2_mouse_packet_tracker.sv
// PS/2 mouse packet tracker.
// Input channel: one mouse byte per transaction on data_byte_i, qualified by
// in_valid_i, held off by in_stall_o. Bytes are grouped into three-byte
// packets; in the header slot a byte without bit 3 set is dropped.
// Output channel: one transaction per completed packet, carrying the clamped
// cursor position and the three button bits, qualified by out_valid_o and
// held off by out_stall_i.
// Configuration: cfg_we_i writes cfg_wdata_i into the register at cfg_idx_i
// (0 screen width, 1 screen height); other indexes are ignored. Write only
// while no packet is in progress and no result is pending.
// Throughput: one byte per cycle while in_stall_o is low. Each byte is held
// in an input register, then the phase step and the add-and-clamp update the
// cursor register, which doubles as the output register.
// Result: a packet's third byte passes the input register, then the phase
// step sets the cursor and button registers and raises out_valid_o.
// Reset: phase returns to the header slot, cursor to (100, 100), buttons
// released, screen to 640 x 480, no result pending.
// Stall: while a result waits, bytes that complete no packet still flow; the
// third byte of the next packet holds in the input register and in_stall_o
// rises until the pending result is taken.
module ps2_mouse_packet_tracker #(
  parameter int unsigned COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ps2mt_pkg::BYTE_W-1:0]     data_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [COORD_BITS-1:0]            pos_x_o,
  output logic [COORD_BITS-1:0]            pos_y_o,
  output logic                             left_down_o,
  output logic                             right_down_o,
  output logic                             middle_down_o,
  input  logic                             cfg_we_i,
  input  logic [ps2mt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ps2mt_pkg::CFG_W-1:0]      cfg_wdata_i
);

  localparam int unsigned BW    = ps2mt_pkg::BYTE_W;
  localparam int unsigned CW    = ps2mt_pkg::CFG_W;
  localparam int unsigned SUM_W = COORD_BITS + 2;

  localparam logic [1:0] PH_HEAD   = 2'd0;
  localparam logic [1:0] PH_MOVE_X = 2'd1;
  localparam logic [1:0] PH_MOVE_Y = 2'd2;

  logic [CW-1:0]         width_q, width_d;
  logic [CW-1:0]         height_q, height_d;
  logic                  s1_valid_q, s1_valid_d;
  logic [BW-1:0]         s1_data_q, s1_data_d;
  logic [1:0]            phase_q, phase_d;
  logic [BW-1:0]         header_q, header_d;
  logic [BW-1:0]         move_x_q, move_x_d;
  logic [COORD_BITS-1:0] cur_x_q, cur_x_d;
  logic [COORD_BITS-1:0] cur_y_q, cur_y_d;
  logic [2:0]            btn_q, btn_d;
  logic                  out_valid_q, out_valid_d;

  logic                  s1_result;
  logic                  s1_adv;
  logic                  s1_fire;
  logic                  in_acc;
  logic [COORD_BITS-1:0] lim_x, lim_y;
  logic [SUM_W-1:0]      sum_x, sum_y;

  function automatic logic [COORD_BITS-1:0] size_limit(input logic [CW-1:0] size);
    logic [CW-1:0] m1;
    begin
      m1 = (size == '0) ? '0 : size - CW'(1);
      if ((m1 >> COORD_BITS) != '0) begin
        size_limit = '1;
      end else begin
        size_limit = COORD_BITS'(m1);
      end
    end
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(input logic [SUM_W-1:0] v,
                                                  input logic [COORD_BITS-1:0] lim);
    begin
      if (v[SUM_W-1]) begin
        clamp = '0;
      end else if (v > SUM_W'(lim)) begin
        clamp = lim;
      end else begin
        clamp = v[COORD_BITS-1:0];
      end
    end
  endfunction

  assign s1_result  = s1_valid_q && (phase_q == PH_MOVE_Y);
  assign s1_adv     = !s1_result || !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign lim_x = size_limit(width_q);
  assign lim_y = size_limit(height_q);
  // X moves by +dx, Y by -dy
  assign sum_x = {2'b00, cur_x_q} + {{(SUM_W-BW){move_x_q[BW-1]}}, move_x_q};
  assign sum_y = {2'b00, cur_y_q} - {{(SUM_W-BW){s1_data_q[BW-1]}}, s1_data_q};

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ps2mt_pkg::CFG_IDX_WIDTH:  width_d  = cfg_wdata_i;
        ps2mt_pkg::CFG_IDX_HEIGHT: height_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_data_d  = s1_data_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
      s1_data_d  = data_byte_i;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    header_d = header_q;
    move_x_d = move_x_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    btn_d    = btn_q;
    if (s1_fire) begin
      case (phase_q)
        PH_MOVE_X: begin
          move_x_d = s1_data_q;
          phase_d  = PH_MOVE_Y;
        end
        PH_MOVE_Y: begin
          phase_d = PH_HEAD;
          cur_x_d = clamp(sum_x, lim_x);
          cur_y_d = clamp(sum_y, lim_y);
          btn_d   = {header_q[ps2mt_pkg::BTN_MIDDLE], header_q[ps2mt_pkg::BTN_RIGHT],
                     header_q[ps2mt_pkg::BTN_LEFT]};
        end
        default: begin
          // drop bytes until one carries the sync bit
          if (s1_data_q[ps2mt_pkg::SYNC_BIT]) begin
            header_d = s1_data_q;
            phase_d  = PH_MOVE_X;
          end else begin
            phase_d = PH_HEAD;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_result) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= ps2mt_pkg::WIDTH_RST;
      height_q    <= ps2mt_pkg::HEIGHT_RST;
      s1_valid_q  <= 1'b0;
      phase_q     <= PH_HEAD;
      header_q    <= '0;
      move_x_q    <= '0;
      cur_x_q     <= COORD_BITS'(ps2mt_pkg::CURSOR_RST);
      cur_y_q     <= COORD_BITS'(ps2mt_pkg::CURSOR_RST);
      btn_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      s1_valid_q  <= s1_valid_d;
      phase_q     <= phase_d;
      header_q    <= header_d;
      move_x_q    <= move_x_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      btn_q       <= btn_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_data_q <= s1_data_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pos_x_o       = cur_x_q;
  assign pos_y_o       = cur_y_q;
  assign left_down_o   = btn_q[0];
  assign right_down_o  = btn_q[1];
  assign middle_down_o = btn_q[2];

endmodule

### hdl/ps2mt_checker.sv
module ps2mt_checker #(
  parameter int unsigned COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic [ps2mt_pkg::BYTE_W-1:0]     data_byte_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [COORD_BITS-1:0]            pos_x_o,
  input logic [COORD_BITS-1:0]            pos_y_o,
  input logic                             left_down_o,
  input logic                             right_down_o,
  input logic                             middle_down_o,
  input logic                             cfg_we_i,
  input logic [ps2mt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [ps2mt_pkg::CFG_W-1:0]      cfg_wdata_i
);

  localparam int unsigned EXT_W = (COORD_BITS > ps2mt_pkg::CFG_W) ?
                                  COORD_BITS + 1 : ps2mt_pkg::CFG_W + 1;

  logic [ps2mt_pkg::CFG_W-1:0] width_q;
  logic [ps2mt_pkg::CFG_W-1:0] height_q;
  logic                        x_ok, y_ok;

  // track the screen size as seen on the config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ps2mt_pkg::WIDTH_RST;
      height_q <= ps2mt_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ps2mt_pkg::CFG_IDX_WIDTH:  width_q  <= cfg_wdata_i;
        ps2mt_pkg::CFG_IDX_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign x_ok = (EXT_W'(pos_x_o) < EXT_W'(width_q)) || (pos_x_o == '0);
  assign y_ok = (EXT_W'(pos_y_o) < EXT_W'(height_q)) || (pos_y_o == '0);

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pos_x_o) && $stable(pos_y_o) &&
      $stable(left_down_o) && $stable(right_down_o) && $stable(middle_down_o))
    else $error("result changed while stalled");

  a_pos_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> x_ok && y_ok)
    else $error("cursor outside configured screen");

  a_result_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a preceding byte transaction");

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker #(.COORD_BITS(COORD_BITS)) u_ps2mt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .data_byte_i   (data_byte_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pos_x_o       (pos_x_o),
  .pos_y_o       (pos_y_o),
  .left_down_o   (left_down_o),
  .right_down_o  (right_down_o),
  .middle_down_o (middle_down_o),
  .cfg_we_i      (cfg_we_i),
  .cfg_idx_i     (cfg_idx_i),
  .cfg_wdata_i   (cfg_wdata_i)
);

### verif/ps2_mouse_packet_tracker_test.sv
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker_test;

  localparam int unsigned BYTE_W    = ps2mt_pkg::BYTE_W;
  localparam int unsigned CFG_W     = ps2mt_pkg::CFG_W;
  localparam int unsigned CFG_IDX_W = ps2mt_pkg::CFG_IDX_W;
  localparam int unsigned COORD_W   = ps2mt_pkg::COORD_BITS_DEF;
  localparam int          COORD_TOP = (1 << COORD_W) - 1;
  localparam int          SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

  typedef enum logic [1:0] {
    SLOT_HEADER = 2'd0,
    SLOT_DX     = 2'd1,
    SLOT_DY     = 2'd2,
    SLOT_SPARE  = 2'd3
  } packet_slot_e;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               left;
    logic               right;
    logic               middle;
  } cursor_report_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    data_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COORD_W-1:0]   pos_x;
  logic [COORD_W-1:0]   pos_y;
  logic                 left_down;
  logic                 right_down;
  logic                 middle_down;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  ps2_mouse_packet_tracker dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .data_byte_i   (data_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .pos_x_o       (pos_x),
    .pos_y_o       (pos_y),
    .left_down_o   (left_down),
    .right_down_o  (right_down),
    .middle_down_o (middle_down),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  // Pending bytes and expected cursor reports
  logic [BYTE_W-1:0] byte_q[$];
  cursor_report_t    report_q[$];

  // Tracker copy: screen, packet slot, cursor
  logic [CFG_W-1:0]   scr_w = ps2mt_pkg::WIDTH_RST;
  logic [CFG_W-1:0]   scr_h = ps2mt_pkg::HEIGHT_RST;
  packet_slot_e       trk_slot = SLOT_HEADER;
  logic [BYTE_W-1:0]  trk_header = '0;
  logic [BYTE_W-1:0]  trk_move_x = '0;
  logic [COORD_W-1:0] cur_x = COORD_W'(ps2mt_pkg::CURSOR_RST);
  logic [COORD_W-1:0] cur_y = COORD_W'(ps2mt_pkg::CURSOR_RST);

  // Slot the generator believes the block is in after the queued bytes
  packet_slot_e gen_slot = SLOT_HEADER;

  int unsigned err_cnt     = 0;
  int unsigned bytes_taken = 0;
  int unsigned reports_ok  = 0;
  int unsigned live_cnt    = 0;
  int unsigned cfg_writes  = 0;
  logic        byte_taken  = 1'b0;

  initial begin
    clk = 1'b0;
  end
  always #10 clk = ~clk;

  function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] pos, int delta,
                                                     logic [CFG_W-1:0] size);
    int lim;
    int v;
    lim = (size == '0) ? 0 : int'(size) - 1;
    if (lim > COORD_TOP) lim = COORD_TOP;
    v = int'(pos) + delta;
    if (v < 0) return '0;
    if (v > lim) return COORD_W'(lim);
    return COORD_W'(v);
  endfunction

  task automatic advance_cursor(input logic [BYTE_W-1:0] b);
    int dx;
    int dy;
    cursor_report_t rep;
    case (trk_slot)
      SLOT_DX: begin
        trk_move_x = b;
        trk_slot   = SLOT_DY;
      end
      SLOT_DY: begin
        dx = int'($signed(trk_move_x));
        dy = int'($signed(b));
        cur_x = clamp_coord(cur_x, dx, scr_w);
        cur_y = clamp_coord(cur_y, -dy, scr_h);
        rep.x      = cur_x;
        rep.y      = cur_y;
        rep.left   = trk_header[ps2mt_pkg::BTN_LEFT];
        rep.right  = trk_header[ps2mt_pkg::BTN_RIGHT];
        rep.middle = trk_header[ps2mt_pkg::BTN_MIDDLE];
        report_q.push_back(rep);
        trk_slot = SLOT_HEADER;
      end
      default: begin
        // header slot, and the unused slot behaves the same
        if (b[ps2mt_pkg::SYNC_BIT]) begin
          trk_header = b;
          trk_slot   = SLOT_DX;
        end else begin
          trk_slot = SLOT_HEADER;
        end
      end
    endcase
  endtask

  // Monitor and prediction
  always @(posedge clk) begin
    cursor_report_t want;
    if (!rst_n) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected report x=%0d y=%0d btn=%b%b%b", $realtime,
                     pos_x, pos_y, middle_down, right_down, left_down);
        end else begin
          want = report_q.pop_front();
          if (pos_x !== want.x || pos_y !== want.y || left_down !== want.left ||
              right_down !== want.right || middle_down !== want.middle) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: report mismatch exp x=%0d y=%0d mrl=%b%b%b got x=%0d y=%0d mrl=%b%b%b",
                       $realtime, want.x, want.y, want.middle, want.right, want.left,
                       pos_x, pos_y, middle_down, right_down, left_down);
          end else begin
            reports_ok++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_cursor(data_byte);
        void'(byte_q.pop_front());
        bytes_taken++;
      end
    end
  end

  // Byte driver: bursts with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    logic              nxt_valid;
    logic [BYTE_W-1:0] nxt_data;
    nxt_valid = in_valid;
    nxt_data  = data_byte;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (in_valid && !byte_taken) begin
      // hold the stalled transaction
    end else if (gap_left > 0) begin
      gap_left--;
      nxt_valid = 1'b0;
    end else if (byte_q.size() > 0) begin
      nxt_valid = 1'b1;
      nxt_data  = byte_q[0];
      burst_left--;
      if (burst_left <= 0) begin
        if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(20, 60);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 8);
          gap_left   = $urandom_range(0, 6);
        end
      end
    end else begin
      nxt_valid = 1'b0;
    end
    in_valid  <= nxt_valid;
    data_byte <= nxt_data;
  end

  // Receiver stall pattern
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_cyc  = 0;

  always @(negedge clk) begin
    logic nxt_stall;
    stall_cyc++;
    if (stall_cyc % 50 == 0) stall_mode = stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_LIGHT:    nxt_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    nxt_stall = ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: nxt_stall = ((stall_cyc % 7) < 3);
      default:        nxt_stall = 1'b0;
    endcase
    out_stall <= nxt_stall;
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    byte_q.push_back(b);
    case (gen_slot)
      SLOT_DX: gen_slot = SLOT_DY;
      SLOT_DY: gen_slot = SLOT_HEADER;
      default: gen_slot = b[ps2mt_pkg::SYNC_BIT] ? SLOT_DX : SLOT_HEADER;
    endcase
    if (!(gen_slot == SLOT_HEADER && byte_q[$] == b && !b[ps2mt_pkg::SYNC_BIT] &&
          byte_q.size() > 0 && gen_slot == SLOT_HEADER)) live_cnt++;
  endtask

  task automatic realign();
    while (gen_slot != SLOT_HEADER) push_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [BYTE_W-1:0] pick_move(int bias);
    int m;
    if (bias > 0) begin
      m = $urandom_range(100, 127);
    end else if (bias < 0) begin
      m = -int'($urandom_range(100, 128));
    end else if ($urandom_range(0, 1) == 0) begin
      m = int'($urandom_range(0, 8)) - 4;
    end else begin
      m = $urandom_range(0, 255);
    end
    return m[BYTE_W-1:0];
  endfunction

  task automatic push_packet(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] dx,
                             input logic [BYTE_W-1:0] dy);
    realign();
    push_byte(hdr);
    push_byte(dx);
    push_byte(dy);
  endtask

  task automatic run_random(input int n, input int bias_x, input int bias_dy);
    int unsigned start;
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] b;
    int r;
    start = live_cnt;
    while (live_cnt - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        hdr = 8'($urandom_range(0, 255));
        hdr[ps2mt_pkg::SYNC_BIT] = 1'b1;
        push_packet(hdr,
                    ($urandom_range(0, 4) != 0) ? pick_move(bias_x) : pick_move(0),
                    ($urandom_range(0, 4) != 0) ? pick_move(bias_dy) : pick_move(0));
      end else if (r < 92) begin
        push_byte(8'($urandom_range(0, 255)));
      end else if (r < 96) begin
        // byte without the sync bit, dropped by the block if a header is due
        b = 8'($urandom_range(0, 255));
        b[ps2mt_pkg::SYNC_BIT] = 1'b0;
        push_byte(b);
      end else begin
        // lone header; the bytes that follow it complete its packet
        hdr = 8'($urandom_range(0, 255));
        hdr[ps2mt_pkg::SYNC_BIT] = 1'b1;
        realign();
        push_byte(hdr);
      end
    end
    realign();
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || report_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    if (idx == ps2mt_pkg::CFG_IDX_WIDTH) scr_w = val;
    else if (idx == ps2mt_pkg::CFG_IDX_HEIGHT) scr_h = val;
    cfg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_screen(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    wait_drained();
    write_reg(ps2mt_pkg::CFG_IDX_WIDTH, w);
    write_reg(ps2mt_pkg::CFG_IDX_HEIGHT, h);
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: dropped bytes, extreme moves, each button, clamp at zero
    push_byte(8'h00);
    push_byte(8'hF7);
    push_packet(8'h08, 8'h7F, 8'h80);
    push_packet(8'hFF, 8'h80, 8'h7F);
    push_packet(8'h09, 8'h00, 8'h00);
    push_packet(8'h0A, 8'h01, 8'hFF);
    push_packet(8'h0C, 8'hFF, 8'h01);
    push_packet(8'h08, 8'h80, 8'h7F);
    push_packet(8'h08, 8'h80, 8'h7F);

    // Zero and unit screen sizes; stray register indexes are ignored
    set_screen(13'd0, 13'd1);
    write_reg(CFG_IDX_SPARE2, 13'h1FFF);
    write_reg(CFG_IDX_SPARE3, 13'h0000);
    run_random(40, 0, 0);
    set_screen(13'd1, 13'd0);
    run_random(30, 0, 0);

    // Oversized screen: drive the cursor into the coordinate ceiling
    set_screen(13'h1FFF, 13'h1FFF);
    run_random(150, 1, -1);
    set_screen(13'd4096, 13'd4096);
    run_random(60, 0, 0);

    // Shrink while the cursor sits far out
    set_screen(13'd16, 13'd9);
    run_random(60, 0, 0);

    set_screen(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
    write_reg(CFG_IDX_SPARE2, 13'($urandom_range(0, 8191)));
    write_reg(CFG_IDX_SPARE3, 13'($urandom_range(0, 8191)));
    run_random(80, 0, 0);

    // Back to the reset screen, pushing toward the origin
    set_screen(ps2mt_pkg::WIDTH_RST, ps2mt_pkg::HEIGHT_RST);
    run_random(60, -1, 1);

    wait_drained();
    $display("covered %0d bytes, %0d checked cursor reports, %0d register writes",
             bytes_taken, reports_ok, cfg_writes);
    $display("screens from 0 to 8191, clamps at both ends, dropped and truncated packets");
    if (err_cnt == 0) begin
      $display("ps2_mouse_packet_tracker_test: clean");
    end else begin
      $display("mismatches: %0d", err_cnt);
      $display("ps2_mouse_packet_tracker_test: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d reports outstanding", report_q.size());
    $display("ps2_mouse_packet_tracker_test: errors");
    $finish;
  end

endmodule

### ps2_mouse_packet_tracker.f
hdl/ps2mt_pkg.sv
hdl/ps2_mouse_packet_tracker.sv
hdl/ps2mt_checker.sv
verif/ps2_mouse_packet_tracker_test.sv
